FILE: hw/rtl/hsfd_pkg.sv
`timescale 1ns / 1ps

package hsfd_pkg;

  localparam int BYTE_W = 8;
  localparam int RAW_W  = 20;
  localparam int FMT_W  = 2;
  localparam int OFS_W  = 10;
  localparam int TEMP_W = 12;
  localparam int HUM_W  = 11;
  localparam int PROD_W = 31;   // 20-bit raw code times an 11-bit scale
  localparam int QUO_W  = 15;   // holds the largest quotient by 65535 of a 20-bit raw code times 1750
  localparam int SUM_W  = 17;   // quotient plus base plus offset, signed

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_FORMAT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_OFS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HUM_OFS  = 2'd2;

  localparam logic [FMT_W-1:0] FMT_A = 2'd0;
  localparam logic [FMT_W-1:0] FMT_B = 2'd1;
  localparam logic [FMT_W-1:0] FMT_C = 2'd2;

  localparam logic [BYTE_W-1:0] CRC_POLY = 8'h31;
  localparam logic [BYTE_W-1:0] CRC_INIT = 8'hFF;

  // Frame handed from the byte tracker to the conversion pipe.
  typedef struct packed {
    logic [FMT_W-1:0] fmt;
    logic [RAW_W-1:0] temp_raw;
    logic [RAW_W-1:0] hum_raw;
    logic             crc_ok;
  } frame_t;

  // CRC-8, MSB first, one byte per call.
  function automatic logic [BYTE_W-1:0] crc8_byte(input logic [BYTE_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] data);
    logic [BYTE_W-1:0] c;
    c = crc ^ data;
    for (int k = 0; k < BYTE_W; k++) begin
      c = c[BYTE_W-1] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  // floor(x / 65535): with q = x >> 16 the remainder is x[15:0] + q, which stays
  // below twice the divisor for any 31-bit x, so one correction step is exact.
  function automatic logic [QUO_W-1:0] div_65535(input logic [PROD_W-1:0] x);
    logic [QUO_W-1:0] q;
    logic [16:0]      r;
    q = x[PROD_W-1:16];
    r = {1'b0, x[15:0]} + {2'b00, q};
    return (r >= 17'd65535) ? q + 1'b1 : q;
  endfunction

endpackage

FILE: hw/rtl/hsfd_frame.sv
`timescale 1ns / 1ps

module hsfd_frame import hsfd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic              adv,
  input  logic [BYTE_W-1:0] raw_byte,
  input  logic              frame_start,
  input  logic [FMT_W-1:0]  fmt,
  output logic              frm_valid,
  output frame_t            frm
);

  localparam logic [2:0] POS_T_CRC  = 3'd2;
  localparam logic [2:0] POS_H_CRC  = 3'd5;
  localparam logic [2:0] POS_CRC_C  = 3'd6;
  localparam logic [2:0] POS_IDLE   = 3'd7;

  logic [2:0]        pos_r, pos_nxt, pos_e, last;
  logic [BYTE_W-1:0] crc_r, crc_nxt, crc_e, crc_upd;
  logic              chk_r, chk_nxt, chk_e;
  logic [RAW_W-1:0]  traw_r, traw_nxt, hraw_r, hraw_nxt;
  logic              fmt_c, emit;
  logic              frm_valid_r, frm_valid_nxt;
  frame_t            frm_r, frm_nxt;

  assign fmt_c   = (fmt == FMT_C);
  assign last    = fmt_c ? POS_CRC_C : POS_H_CRC;
  assign pos_e   = frame_start ? 3'd0 : pos_r;
  assign crc_e   = frame_start ? CRC_INIT : crc_r;
  assign chk_e   = frame_start ? 1'b1 : chk_r;
  assign crc_upd = crc8_byte(crc_e, raw_byte);

  always_comb begin
    pos_nxt  = pos_r;
    crc_nxt  = crc_r;
    chk_nxt  = chk_r;
    traw_nxt = traw_r;
    hraw_nxt = hraw_r;
    emit     = 1'b0;
    if (accept) begin
      pos_nxt = pos_e;
      crc_nxt = crc_e;
      chk_nxt = chk_e;
      if (pos_e > last) begin
        pos_nxt = POS_IDLE;
      end else if (fmt_c) begin
        if (pos_e == POS_CRC_C) begin
          chk_nxt = chk_e & (raw_byte == crc_e);
          pos_nxt = POS_IDLE;
          emit    = 1'b1;
        end else begin
          crc_nxt = crc_upd;
          pos_nxt = pos_e + 3'd1;
          case (pos_e)
            3'd1: hraw_nxt = {12'd0, raw_byte};
            3'd2: hraw_nxt = {hraw_r[11:0], raw_byte};
            3'd3: begin
              hraw_nxt = {hraw_r[15:0], raw_byte[7:4]};
              traw_nxt = {16'd0, raw_byte[3:0]};
            end
            3'd4, 3'd5: traw_nxt = {traw_r[11:0], raw_byte};
            default: ;
          endcase
        end
      end else begin
        if (pos_e == POS_T_CRC || pos_e == POS_H_CRC) begin
          chk_nxt = chk_e & (raw_byte == crc_e);
          crc_nxt = CRC_INIT;
        end else begin
          crc_nxt = crc_upd;
          case (pos_e)
            3'd0:    traw_nxt = {12'd0, raw_byte};
            3'd1:    traw_nxt = {4'd0, traw_r[7:0], raw_byte};
            3'd3:    hraw_nxt = {12'd0, raw_byte};
            default: hraw_nxt = {4'd0, hraw_r[7:0], raw_byte};
          endcase
        end
        if (pos_e == POS_H_CRC) begin
          pos_nxt = POS_IDLE;
          emit    = 1'b1;
        end else begin
          pos_nxt = pos_e + 3'd1;
        end
      end
    end
  end

  always_comb begin
    frm_valid_nxt = adv ? emit : frm_valid_r;
    frm_nxt       = frm_r;
    if (emit) begin
      frm_nxt.fmt      = fmt;
      frm_nxt.temp_raw = traw_nxt;
      frm_nxt.hum_raw  = hraw_nxt;
      frm_nxt.crc_ok   = chk_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= 3'd0;
      crc_r       <= CRC_INIT;
      chk_r       <= 1'b1;
      traw_r      <= '0;
      hraw_r      <= '0;
      frm_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      crc_r       <= crc_nxt;
      chk_r       <= chk_nxt;
      traw_r      <= traw_nxt;
      hraw_r      <= hraw_nxt;
      frm_valid_r <= frm_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    frm_r <= frm_nxt;
  end

  assign frm_valid = frm_valid_r;
  assign frm       = frm_r;

endmodule

FILE: hw/rtl/hsfd_conv.sv
`timescale 1ns / 1ps

module hsfd_conv import hsfd_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     adv,
  input  logic                     frm_valid,
  input  frame_t                   frm,
  input  logic signed [OFS_W-1:0]  temp_ofs,
  input  logic signed [OFS_W-1:0]  hum_ofs,
  output logic                     out_valid,
  output logic signed [TEMP_W-1:0] out_temperature,
  output logic signed [HUM_W-1:0]  out_humidity,
  output logic                     out_crc_ok
);

  localparam logic [10:0] T_SCALE_AB = 11'd1750;
  localparam logic [10:0] T_SCALE_C  = 11'd2000;
  localparam logic [10:0] H_SCALE_A  = 11'd1000;
  localparam logic [10:0] H_SCALE_B  = 11'd1250;
  localparam logic signed [SUM_W-1:0] T_BASE_AB = -17'sd450;
  localparam logic signed [SUM_W-1:0] T_BASE_C  = -17'sd500;
  localparam logic signed [SUM_W-1:0] H_BASE_B  = -17'sd60;
  localparam logic signed [SUM_W-1:0] H_MAX     = 17'sd1000;

  // multiply stage
  logic [10:0]       t_scale, h_scale;
  logic              mul_valid_r, mul_valid_nxt;
  logic [PROD_W-1:0] pt_r, pt_nxt, ph_r, ph_nxt;
  logic [FMT_W-1:0]  mfmt_r, mfmt_nxt;
  logic              mchk_r, mchk_nxt;

  assign t_scale = (frm.fmt == FMT_C) ? T_SCALE_C : T_SCALE_AB;
  assign h_scale = (frm.fmt == FMT_B) ? H_SCALE_B : H_SCALE_A;

  always_comb begin
    mul_valid_nxt = adv ? frm_valid : mul_valid_r;
    pt_nxt        = pt_r;
    ph_nxt        = ph_r;
    mfmt_nxt      = mfmt_r;
    mchk_nxt      = mchk_r;
    if (adv) begin
      pt_nxt   = PROD_W'(frm.temp_raw) * PROD_W'(t_scale);
      ph_nxt   = PROD_W'(frm.hum_raw) * PROD_W'(h_scale);
      mfmt_nxt = frm.fmt;
      mchk_nxt = frm.crc_ok;
    end
  end

  // scale, offset and clamp stage
  logic                     is_c, is_b;
  logic [QUO_W-1:0]         qt, qh;
  logic signed [SUM_W-1:0]  tsum, hsum, hclamp;
  logic                     out_valid_r, out_valid_nxt;
  logic signed [TEMP_W-1:0] temp_r, temp_nxt;
  logic signed [HUM_W-1:0]  hum_r, hum_nxt;
  logic                     crc_ok_r, crc_ok_nxt;

  assign is_c = (mfmt_r == FMT_C);
  assign is_b = (mfmt_r == FMT_B);
  assign qt   = is_c ? QUO_W'(pt_r[PROD_W-1:RAW_W]) : div_65535(pt_r);
  assign qh   = is_c ? QUO_W'(ph_r[PROD_W-1:RAW_W]) : div_65535(ph_r);

  always_comb begin
    tsum = $signed({2'b00, qt}) + (is_c ? T_BASE_C : T_BASE_AB)
           + SUM_W'(temp_ofs);
    hsum = $signed({2'b00, qh}) + (is_b ? H_BASE_B : '0) + SUM_W'(hum_ofs);
    hclamp = hsum;
    if (hsum > H_MAX) begin
      hclamp = H_MAX;
    end else if (is_b && hsum < 0) begin
      hclamp = '0;
    end
  end

  always_comb begin
    out_valid_nxt = adv ? mul_valid_r : out_valid_r;
    temp_nxt      = temp_r;
    hum_nxt       = hum_r;
    crc_ok_nxt    = crc_ok_r;
    if (adv) begin
      temp_nxt   = tsum[TEMP_W-1:0];
      hum_nxt    = hclamp[HUM_W-1:0];
      crc_ok_nxt = mchk_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      mul_valid_r <= mul_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pt_r     <= pt_nxt;
    ph_r     <= ph_nxt;
    mfmt_r   <= mfmt_nxt;
    mchk_r   <= mchk_nxt;
    temp_r   <= temp_nxt;
    hum_r    <= hum_nxt;
    crc_ok_r <= crc_ok_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_temperature = temp_r;
  assign out_humidity    = hum_r;
  assign out_crc_ok      = crc_ok_r;

endmodule

FILE: hw/rtl/humidity_sensor_frame_decoder_core.sv
`timescale 1ns / 1ps
// Path: on the transfer of a frame's last byte the frame register loads, then the
//   multiply register, then the output register, which shows the result.
// Throughput: one byte per cycle; the three stages move together and stop only
//   while a result waits in the output register under out_stall.
// Reset (rst_n low, synchronous): clears stage valids, frame position, CRC, check
//   flag, raw codes and config registers; pipeline data registers are not reset.

module humidity_sensor_frame_decoder_core import hsfd_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  // byte input channel
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [BYTE_W-1:0]        in_raw_byte,
  input  logic                     in_frame_start,
  // result channel
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [TEMP_W-1:0] out_temperature,
  output logic signed [HUM_W-1:0]  out_humidity,
  output logic                     out_crc_ok,
  // configuration writes
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [OFS_W-1:0]         cfg_wdata
);

  // Config registers. Writes to an index outside the list are dropped.
  logic [FMT_W-1:0]        fmt_r, fmt_nxt;
  logic signed [OFS_W-1:0] tofs_r, tofs_nxt;
  logic signed [OFS_W-1:0] hofs_r, hofs_nxt;

  always_comb begin
    fmt_nxt  = fmt_r;
    tofs_nxt = tofs_r;
    hofs_nxt = hofs_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_FORMAT:   fmt_nxt  = cfg_wdata[FMT_W-1:0];
        REG_TEMP_OFS: tofs_nxt = cfg_wdata;
        REG_HUM_OFS:  hofs_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r  <= FMT_A;
      tofs_r <= '0;
      hofs_r <= '0;
    end else begin
      fmt_r  <= fmt_nxt;
      tofs_r <= tofs_nxt;
      hofs_r <= hofs_nxt;
    end
  end

  // Whole pipe advances unless a finished result is held by the sink.
  // Bytes are accepted whenever the pipe advances.
  logic   adv, in_xfer;
  logic   frm_valid;
  frame_t frm;

  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;
  assign in_xfer  = in_valid && adv;

  // Byte tracker: position, running CRC, raw codes; registers each finished frame.
  hsfd_frame u_frame (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (in_xfer),
    .adv         (adv),
    .raw_byte    (in_raw_byte),
    .frame_start (in_frame_start),
    .fmt         (fmt_r),
    .frm_valid   (frm_valid),
    .frm         (frm)
  );

  // Conversion: scale multiply, then divide/shift, offset, clamp into the output register.
  hsfd_conv u_conv (
    .clk             (clk),
    .rst_n           (rst_n),
    .adv             (adv),
    .frm_valid       (frm_valid),
    .frm             (frm),
    .temp_ofs        (tofs_r),
    .hum_ofs         (hofs_r),
    .out_valid       (out_valid),
    .out_temperature (out_temperature),
    .out_humidity    (out_humidity),
    .out_crc_ok      (out_crc_ok)
  );

endmodule

FILE: hw/rtl/hsfd_checker.sv
`timescale 1ns / 1ps

module hsfd_checker import hsfd_pkg::*; (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_stall,
  input logic [BYTE_W-1:0]        in_raw_byte,
  input logic                     in_frame_start,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic signed [TEMP_W-1:0] out_temperature,
  input logic signed [HUM_W-1:0]  out_humidity,
  input logic                     out_crc_ok,
  input logic                     cfg_we,
  input logic [CFG_IDX_W-1:0]     cfg_index,
  input logic [OFS_W-1:0]         cfg_wdata
);

  // A held result keeps its value until the transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_temperature)
      && $stable(out_humidity) && $stable(out_crc_ok))
    else $error("result changed while stalled");

  // Input back-pressure only comes from a held result.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a held result");

  // Humidity never exceeds the upper clamp.
  a_hum_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_humidity <= 11'sd1000)
    else $error("humidity above clamp");

  // No result right after reset.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind humidity_sensor_frame_decoder_core hsfd_checker u_hsfd_checker (.*);
